// ===== sv/swbp_pkg.sv =====
package swbp_pkg;

  // Default sizes
  localparam int CHANNELS_DEF    = 16;
  localparam int WINDOW_MAX_DEF  = 256;
  localparam int MAX_BANDS_DEF   = 4;
  localparam int SAMPLE_BITS_DEF = 16;

  // Datapath widths and latencies
  localparam int CORDIC_N = 16;           // rotation stages
  localparam int TAG_N    = CORDIC_N + 3; // issue to product-valid
  localparam int FIN_LAT  = 5;            // accumulator to power register
  localparam int X_W      = 25;           // widened sample
  localparam int TRIG_W   = 18;           // cos/sin, Q15 plus headroom
  localparam int ACC_W    = 64;
  localparam int LEN_W    = 9;
  localparam int NB_W     = 3;

  // Register reset values
  localparam logic [8:0]  WINDOW_LENGTH_RST   = 9'd64;
  localparam logic [2:0]  BAND_COUNT_RST      = 3'd3;
  localparam logic [15:0] BAND_STEP_RST       = 16'd0;
  localparam logic [24:0] AMPLITUDE_SCALE_RST = 25'd131072;
  localparam logic [24:0] AMPLITUDE_MAX       = 25'd16777216;

  typedef enum logic [2:0] {
    REG_WINDOW_LENGTH,
    REG_BAND_COUNT,
    REG_BAND_STEP_0,
    REG_BAND_STEP_1,
    REG_BAND_STEP_2,
    REG_BAND_STEP_3,
    REG_AMPLITUDE_SCALE
  } reg_index_t;

  // Controller to datapath
  typedef struct packed {
    logic       clear_step;
    logic       push;
    logic       band_start;
    logic       issue;
    logic       load_out;
    logic       last;
    logic [1:0] band;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic             clear_last;
    logic             busy;
    logic             in_ok;
    logic             in_end;
    logic [LEN_W-1:0] len;
    logic [NB_W-1:0]  nb;
  } status_t;

  // Rotation angles in units of 2^-16 turn
  function automatic logic signed [TRIG_W-1:0] atan_turn(input int i);
    logic signed [TRIG_W-1:0] r;
    case (i)
      0:       r = 18'sd8192;
      1:       r = 18'sd4836;
      2:       r = 18'sd2555;
      3:       r = 18'sd1297;
      4:       r = 18'sd651;
      5:       r = 18'sd326;
      6:       r = 18'sd163;
      7:       r = 18'sd81;
      8:       r = 18'sd41;
      9:       r = 18'sd20;
      10:      r = 18'sd10;
      11:      r = 18'sd5;
      12:      r = 18'sd3;
      13:      r = 18'sd1;
      14:      r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/swbp_ram.sv =====
module swbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/swbp_cordic.sv =====
module swbp_cordic (
  input  logic                                  clk,
  input  logic [15:0]                           phase,
  output logic signed [swbp_pkg::TRIG_W-1:0]    cos_v,
  output logic signed [swbp_pkg::TRIG_W-1:0]    sin_v
);

  localparam int N = swbp_pkg::CORDIC_N;

  logic signed [swbp_pkg::TRIG_W-1:0] xs [N+1];
  logic signed [swbp_pkg::TRIG_W-1:0] ys [N+1];
  logic signed [swbp_pkg::TRIG_W-1:0] zs [N+1];
  logic [1:0]                         qs [N+1];

  // One rotation per stage; the quadrant rides along
  always_ff @(posedge clk) begin
    xs[0] <= 18'sd19898;
    ys[0] <= '0;
    zs[0] <= signed'({4'b0000, phase[13:0]});
    qs[0] <= phase[15:14];
    for (int i = 0; i < N; i++) begin
      if (!zs[i][swbp_pkg::TRIG_W-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - swbp_pkg::atan_turn(i);
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + swbp_pkg::atan_turn(i);
      end
      qs[i+1] <= qs[i];
    end
  end

  // Quadrant fold-out
  always_ff @(posedge clk) begin
    case (qs[N])
      2'd0: begin
        cos_v <= xs[N];
        sin_v <= ys[N];
      end
      2'd1: begin
        cos_v <= -ys[N];
        sin_v <= xs[N];
      end
      2'd2: begin
        cos_v <= -xs[N];
        sin_v <= -ys[N];
      end
      default: begin
        cos_v <= ys[N];
        sin_v <= -xs[N];
      end
    endcase
  end

endmodule

// ===== sv/swbp_dp.sv =====
module swbp_dp #(
  parameter int CHANNELS    = swbp_pkg::CHANNELS_DEF,
  parameter int WINDOW_MAX  = swbp_pkg::WINDOW_MAX_DEF,
  parameter int MAX_BANDS   = swbp_pkg::MAX_BANDS_DEF,
  parameter int SAMPLE_BITS = swbp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  swbp_pkg::cmd_t      cmd,
  output swbp_pkg::status_t   st,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [24:0]         cfg_data,
  input  logic [3:0]          channel,
  input  logic signed [15:0]  sample,
  input  logic                block_end,
  output logic [3:0]          out_channel,
  output logic [1:0]          band,
  output logic [31:0]         power,
  output logic                last
);

  localparam int DEPTH = CHANNELS * WINDOW_MAX;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = $clog2(WINDOW_MAX);
  localparam int TW    = swbp_pkg::TRIG_W;
  localparam int XW    = swbp_pkg::X_W;
  localparam int TN    = swbp_pkg::TAG_N;
  localparam int PRW   = XW + TW;
  localparam logic signed [63:0] ACC_LIM = (64'sd1 <<< 39) - 64'sd1;

  // Configuration registers
  logic [8:0]  window_length;
  logic [2:0]  band_count;
  logic [15:0] band_step [4];
  logic [24:0] amplitude_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length   <= swbp_pkg::WINDOW_LENGTH_RST;
      band_count      <= swbp_pkg::BAND_COUNT_RST;
      for (int k = 0; k < 4; k++) begin
        band_step[k] <= swbp_pkg::BAND_STEP_RST;
      end
      amplitude_scale <= swbp_pkg::AMPLITUDE_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        swbp_pkg::REG_WINDOW_LENGTH:   window_length   <= cfg_data[8:0];
        swbp_pkg::REG_BAND_COUNT:      band_count      <= cfg_data[2:0];
        swbp_pkg::REG_BAND_STEP_0:     band_step[0]    <= cfg_data[15:0];
        swbp_pkg::REG_BAND_STEP_1:     band_step[1]    <= cfg_data[15:0];
        swbp_pkg::REG_BAND_STEP_2:     band_step[2]    <= cfg_data[15:0];
        swbp_pkg::REG_BAND_STEP_3:     band_step[3]    <= cfg_data[15:0];
        swbp_pkg::REG_AMPLITUDE_SCALE: amplitude_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped settings
  logic [8:0]  len;
  logic [2:0]  nb;
  logic [24:0] amp;

  assign len = (32'(window_length) > WINDOW_MAX) ? 9'(WINDOW_MAX) : window_length;
  assign nb  = (32'(band_count) > MAX_BANDS) ? 3'(MAX_BANDS) : band_count;
  assign amp = (amplitude_scale > swbp_pkg::AMPLITUDE_MAX) ? swbp_pkg::AMPLITUDE_MAX
                                                           : amplitude_scale;

  // Write heads, clear sweep address, captured channel
  logic [PW-1:0] head [CHANNELS];
  logic [AW-1:0] clr_addr;
  logic [CW-1:0] in_idx;
  logic [CW-1:0] ch_idx;
  logic [3:0]    ch_reg;
  logic [AW-1:0] base_reg;
  logic [AW-1:0] in_base;
  logic [PW-1:0] in_head;
  logic          in_ok;

  assign in_idx  = CW'(channel);
  assign in_ok   = 32'(channel) < CHANNELS;
  assign in_head = head[in_idx];
  assign in_base = AW'(in_idx * WINDOW_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        head[k] <= '0;
      end
      clr_addr <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.push) begin
        head[in_idx] <= (in_head == PW'(WINDOW_MAX - 1)) ? '0 : in_head + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ch_reg   <= channel;
      ch_idx   <= in_idx;
      base_reg <= in_base;
    end
  end

  // Window walk: read position and phase accumulator
  logic [PW-1:0] pos;
  logic [PW-1:0] cur_head;
  logic [PW-1:0] start_pos;
  logic [15:0]   phase;
  logic [AW-1:0] raddr;

  assign cur_head  = head[ch_idx];
  assign start_pos = (32'(cur_head) >= 32'(len)) ? cur_head - PW'(len)
                                                 : PW'(32'(cur_head) + WINDOW_MAX - 32'(len));
  assign raddr     = base_reg + AW'(pos);

  always_ff @(posedge clk) begin
    if (cmd.band_start) begin
      pos   <= start_pos;
      phase <= '0;
    end else if (cmd.issue) begin
      pos   <= (pos == PW'(WINDOW_MAX - 1)) ? '0 : pos + PW'(1);
      phase <= phase + band_step[cmd.band];
    end
  end

  // Sample store
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [15:0]   rdata;

  always_comb begin
    we    = cmd.clear_step | cmd.push;
    waddr = cmd.clear_step ? clr_addr : in_base + AW'(in_head);
    wdata = cmd.clear_step ? '0 : sample;
  end

  swbp_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Trig source
  logic signed [TW-1:0] cos_v;
  logic signed [TW-1:0] sin_v;

  swbp_cordic u_cordic (
    .clk   (clk),
    .phase (phase),
    .cos_v (cos_v),
    .sin_v (sin_v)
  );

  // Sample delay matching the rotation pipeline
  logic [15:0] dly [swbp_pkg::CORDIC_N+1];

  always_ff @(posedge clk) begin
    dly[0] <= rdata;
    for (int k = 0; k < swbp_pkg::CORDIC_N; k++) begin
      dly[k+1] <= dly[k];
    end
  end

  // Low SAMPLE_BITS of the stored word, sign-extended
  function automatic logic signed [XW-1:0] widen(input logic [15:0] v);
    logic          sgn;
    logic [XW-1:0] r;
    sgn = 1'b0;
    r   = '0;
    for (int k = 0; k < 16; k++) begin
      if (k == SAMPLE_BITS - 1) sgn = v[k];
      if (k < SAMPLE_BITS) r[k] = v[k];
    end
    for (int k = 0; k < XW; k++) begin
      if (k >= SAMPLE_BITS) r[k] = sgn;
    end
    return signed'(r);
  endfunction

  // Valid tags from issue to product
  logic [TN-1:0] tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag <= '0;
    end else begin
      tag <= {tag[TN-2:0], cmd.issue};
    end
  end

  // Multiply and accumulate
  logic signed [XW-1:0]  x_d;
  logic signed [PRW-1:0] prod_re;
  logic signed [PRW-1:0] prod_im;
  logic signed [63:0]    acc_re;
  logic signed [63:0]    acc_im;

  assign x_d = widen(dly[swbp_pkg::CORDIC_N]);

  always_ff @(posedge clk) begin
    prod_re <= x_d * cos_v;
    prod_im <= x_d * sin_v;
    if (cmd.band_start) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (tag[TN-1]) begin
      acc_re <= acc_re + 64'(prod_re);
      acc_im <= acc_im + 64'(prod_im);
    end
  end

  // Saturated magnitude
  function automatic logic [38:0] sat_abs(input logic signed [63:0] a);
    logic signed [63:0] r;
    if (a > ACC_LIM) r = ACC_LIM;
    else if (a < -ACC_LIM) r = ACC_LIM;
    else if (a < 0) r = -a;
    else r = a;
    return r[38:0];
  endfunction

  // Finishing pipeline: magnitude, scale, square, sum
  logic [38:0] mag_re, mag_im;
  logic [44:0] pl_re, pl_im;
  logic [43:0] ph_re, ph_im;
  logic [32:0] m_re, m_im;
  logic [47:0] sq_re, sq_im;
  logic        big_re, big_im;
  logic [31:0] pw;
  logic [63:0] sum_re, sum_im;
  logic [48:0] sq_sum;

  assign sum_re = {ph_re, 20'b0} + 64'(pl_re);
  assign sum_im = {ph_im, 20'b0} + 64'(pl_im);
  assign sq_sum = {1'b0, sq_re} + {1'b0, sq_im};

  always_ff @(posedge clk) begin
    mag_re <= sat_abs(acc_re);
    mag_im <= sat_abs(acc_im);
    pl_re  <= mag_re[19:0] * amp;
    pl_im  <= mag_im[19:0] * amp;
    ph_re  <= mag_re[38:20] * amp;
    ph_im  <= mag_im[38:20] * amp;
    m_re   <= 33'(sum_re >> 31);
    m_im   <= 33'(sum_im >> 31);
    sq_re  <= m_re[23:0] * m_re[23:0];
    sq_im  <= m_im[23:0] * m_im[23:0];
    big_re <= |m_re[32:24];
    big_im <= |m_im[32:24];
    pw     <= (big_re | big_im | sq_sum[48]) ? '1 : sq_sum[47:16];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_channel <= ch_reg;
      band        <= cmd.band;
      power       <= pw;
      last        <= cmd.last;
    end
  end

  // Status
  always_comb begin
    st.clear_last = clr_addr == AW'(DEPTH - 1);
    st.busy       = |tag;
    st.in_ok      = in_ok;
    st.in_end     = block_end;
    st.len        = len;
    st.nb         = nb;
  end

endmodule

// ===== sv/swbp_ctrl.sv =====
module swbp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output swbp_pkg::cmd_t    cmd,
  input  swbp_pkg::status_t st
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_ISSUE,
    S_DRAIN,
    S_FIN,
    S_OUT
  } state_t;

  state_t                       state;
  logic [swbp_pkg::LEN_W-1:0]   j;
  logic [1:0]                   band;
  logic [2:0]                   fcnt;
  logic                         is_last;
  logic                         take;

  assign is_last  = ({1'b0, band} + 3'd1) == st.nb;
  assign in_stall = state != S_IDLE;
  assign take     = in_valid && state == S_IDLE;

  // Commands
  always_comb begin
    cmd            = '0;
    cmd.band       = band;
    cmd.last       = is_last;
    cmd.clear_step = state == S_CLEAR;
    cmd.push       = take && st.in_ok;
    cmd.band_start = state == S_SETUP;
    cmd.issue      = state == S_ISSUE;
    cmd.load_out   = state == S_FIN && fcnt == 3'(swbp_pkg::FIN_LAT - 1);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
      j         <= '0;
      band      <= '0;
      fcnt      <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (st.clear_last) state <= S_IDLE;
        end
        S_IDLE: begin
          if (take && st.in_ok && st.in_end && st.nb != '0) begin
            band  <= '0;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          j     <= '0;
          state <= (st.len == '0) ? S_DRAIN : S_ISSUE;
        end
        S_ISSUE: begin
          j <= j + 1'b1;
          if (j == st.len - 1'b1) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!st.busy) begin
            fcnt  <= '0;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          fcnt <= fcnt + 3'd1;
          if (cmd.load_out) begin
            out_valid <= 1'b1;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (is_last) begin
              state <= S_IDLE;
            end else begin
              band  <= band + 2'd1;
              state <= S_SETUP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // No new sample while a result is pending
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  // Result loaded only once the accumulator has settled
  a_load_settled: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !st.busy)
    else $error("result loaded with products in flight");

  // Never walk past the window
  a_issue_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> j < st.len)
    else $error("read beyond window");

endmodule

// ===== sv/sliding_window_band_power_unit.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_stall    channel, sample, block_end
// output    out_valid / out_stall  out_channel, band, power, last
// config    cfg_we                 cfg_index, cfg_data
//
// A sample without block_end leaves the unit in its idle state, so in_stall stays low for the next sample.
// A block end runs, per band, a walk over the window plus the output wait:
// one sample read and one rotation per cycle, then pipeline drain and finishing.
// After reset the sample store is zeroed word by word, with in_stall high.
// Reset is synchronous; config writes are taken at any time.
module sliding_window_band_power_unit #(
  parameter int CHANNELS    = swbp_pkg::CHANNELS_DEF,
  parameter int WINDOW_MAX  = swbp_pkg::WINDOW_MAX_DEF,
  parameter int MAX_BANDS   = swbp_pkg::MAX_BANDS_DEF,
  parameter int SAMPLE_BITS = swbp_pkg::SAMPLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         channel,
  input  logic signed [15:0] sample,
  input  logic               block_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_channel,
  output logic [1:0]         band,
  output logic [31:0]        power,
  output logic               last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [24:0]        cfg_data
);

  swbp_pkg::cmd_t    cmd;
  swbp_pkg::status_t st;

  swbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  swbp_dp #(
    .CHANNELS    (CHANNELS),
    .WINDOW_MAX  (WINDOW_MAX),
    .MAX_BANDS   (MAX_BANDS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .channel     (channel),
    .sample      (sample),
    .block_end   (block_end),
    .out_channel (out_channel),
    .band        (band),
    .power       (power),
    .last        (last)
  );

endmodule

// ===== tb/sv/sliding_window_band_power_unit_tb.sv =====
module sliding_window_band_power_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [3:0]         chan;
    logic signed [15:0] smp;
    logic               blk_end;
  } sample_item_t;

  typedef struct {
    logic [3:0]  chan;
    logic [1:0]  bnd;
    logic [31:0] pwr;
    logic        lst;
  } band_power_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] channel = '0;
  logic signed [15:0] sample = '0;
  logic block_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] out_channel;
  logic [1:0] band;
  logic [31:0] power;
  logic last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [24:0] cfg_data = '0;

  sliding_window_band_power_unit dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic [8:0]  win_len;
  logic [2:0]  n_bands;
  logic [15:0] steps [4];
  logic [24:0] amp_scale;
  logic [15:0] ring [16][256];
  logic [7:0]  head_pos [16];

  sample_item_t pending_samples[$];
  band_power_t  expected_powers[$];
  int  fail_count = 0;
  int  sent_count = 0;
  bit  hold_rx = 1'b0;

  // CORDIC rotation of a 16-bit phase to Q15 cos/sin
  function automatic void phase_trig(input logic [15:0] ph, output int c, output int s);
    int x, y, z, dx, dy;
    x = 19898; y = 0; z = ph[13:0];
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= swbp_pkg::atan_turn(i);
      end else begin
        x += dx; y -= dy; z += swbp_pkg::atan_turn(i);
      end
    end
    case (ph[15:14])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint unsigned scaled_amp(input longint acc);
    longint lim;
    longint unsigned a;
    lim = (64'sd1 <<< 39) - 1;
    a = (amp_scale > 25'd16777216) ? 64'd16777216 : 64'(amp_scale);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    if (acc < 0) acc = -acc;
    return (longint'(acc) * a) >> 31;
  endfunction

  // push into the window and queue the band powers a block end causes
  task automatic predict_band_powers(input sample_item_t it);
    int len, nb, pos, c, s;
    logic [15:0] ph;
    longint re, im;
    longint unsigned mr, mi, pw;
    band_power_t r;
    ring[it.chan][head_pos[it.chan]] = it.smp;
    head_pos[it.chan] = head_pos[it.chan] + 8'd1;
    if (!it.blk_end) return;
    len = (win_len > 256) ? 256 : win_len;
    nb = (n_bands > 4) ? 4 : n_bands;
    for (int b = 0; b < nb; b++) begin
      ph = '0; re = 0; im = 0;
      pos = (head_pos[it.chan] + 256 - len) % 256;
      for (int j = 0; j < len; j++) begin
        phase_trig(ph, c, s);
        re += longint'($signed(ring[it.chan][pos])) * c;
        im += longint'($signed(ring[it.chan][pos])) * s;
        ph = ph + steps[b];
        pos = (pos + 1) % 256;
      end
      mr = scaled_amp(re);
      mi = scaled_amp(im);
      if (mr >= (64'd1 << 24) || mi >= (64'd1 << 24)) pw = 64'hFFFF_FFFF;
      else begin
        pw = (mr * mr + mi * mi) >> 16;
        if (pw > 64'hFFFF_FFFF) pw = 64'hFFFF_FFFF;
      end
      r.chan = it.chan; r.bnd = b[1:0]; r.pwr = pw[31:0]; r.lst = (b + 1 == nb);
      expected_powers = {expected_powers, r};
    end
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // driver: one transfer per accepted item, random gaps between
  int tx_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_band_powers(pending_samples.pop_front());
        sent_count++;
        tx_gap = gap_len();
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          in_valid <= 1'b1;
          channel <= pending_samples[0].chan;
          sample <= pending_samples[0].smp;
          block_end <= pending_samples[0].blk_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  int rx_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_powers.size() == 0) begin
          $display("%0t: unexpected result ch=%0d band=%0d power=%0d last=%0d",
                   $time, out_channel, band, power, last);
          fail_count++;
        end else begin
          band_power_t e;
          e = expected_powers.pop_front();
          if (e.chan !== out_channel || e.bnd !== band || e.pwr !== power ||
              e.lst !== last) begin
            $display("%0t: mismatch expected ch=%0d band=%0d power=%0d last=%0d",
                     $time, e.chan, e.bnd, e.pwr, e.lst);
            $display("%0t:          actual   ch=%0d band=%0d power=%0d last=%0d",
                     $time, out_channel, band, power, last);
            fail_count++;
          end
        end
      end
      if (rx_gap > 0) rx_gap--;
      else rx_gap = gap_len();
      out_stall <= hold_rx || (rx_gap > 0);
    end
  end

  // one write, then cfg_we is dropped and held low before the next one may start
  task automatic write_reg(input swbp_pkg::reg_index_t idx, input logic [24:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      swbp_pkg::REG_WINDOW_LENGTH:   win_len = val[8:0];
      swbp_pkg::REG_BAND_COUNT:      n_bands = val[2:0];
      swbp_pkg::REG_BAND_STEP_0:     steps[0] = val[15:0];
      swbp_pkg::REG_BAND_STEP_1:     steps[1] = val[15:0];
      swbp_pkg::REG_BAND_STEP_2:     steps[2] = val[15:0];
      swbp_pkg::REG_BAND_STEP_3:     steps[3] = val[15:0];
      default:                       amp_scale = val;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (pending_samples.size() > 0 || expected_powers.size() > 0 || in_valid)
      @(posedge clk);
    repeat (300 * 4) @(posedge clk);
  endtask

  task automatic add_sample(input int ch, input int smp, input bit be);
    sample_item_t it;
    it.chan = 4'(ch); it.smp = 16'(smp); it.blk_end = be;
    pending_samples = {pending_samples, it};
  endtask

  // mostly short runs on one channel ending in a block end, some lone samples in between
  task automatic add_random_run(input int n);
    int ch;
    for (int i = 0; i < n; i++) begin
      ch = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) add_sample(ch, $urandom, 1'b0);
      else begin
        repeat ($urandom_range(1, 12)) add_sample(ch, $urandom, 1'b0);
        add_sample(ch, $urandom_range(0, 3) == 0 ? 32767 : $urandom, 1'b1);
        i += 3;
      end
    end
  endtask

  task automatic random_config(input bit wide);
    write_reg(swbp_pkg::REG_WINDOW_LENGTH,
              25'(wide ? $urandom_range(0, 511) : $urandom_range(2, 40)));
    write_reg(swbp_pkg::REG_BAND_COUNT, 25'($urandom_range(0, 7)));
    write_reg(swbp_pkg::REG_BAND_STEP_0, 25'($urandom_range(0, 65535)));
    write_reg(swbp_pkg::REG_BAND_STEP_1, 25'($urandom_range(0, 32768)));
    write_reg(swbp_pkg::REG_BAND_STEP_2, 25'($urandom_range(0, 65535)));
    write_reg(swbp_pkg::REG_BAND_STEP_3, 25'($urandom_range(0, 32768)));
    write_reg(swbp_pkg::REG_AMPLITUDE_SCALE, 25'($urandom_range(0, 33554431)));
  endtask

  // long receiver hold-off while the sender keeps offering items
  initial begin
    wait (sent_count > 60);
    hold_rx = 1'b1;
    repeat (3000) @(posedge clk);
    hold_rx = 1'b0;
  end

  initial begin
    win_len = swbp_pkg::WINDOW_LENGTH_RST; n_bands = swbp_pkg::BAND_COUNT_RST;
    for (int i = 0; i < 4; i++) steps[i] = swbp_pkg::BAND_STEP_RST;
    amp_scale = swbp_pkg::AMPLITUDE_SCALE_RST;
    for (int c = 0; c < 16; c++) begin
      head_pos[c] = '0;
      for (int p = 0; p < 256; p++) ring[c][p] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero window, extreme samples, empty channel
    add_sample(0, 0, 1'b1);
    add_sample(15, -32768, 1'b0);
    add_sample(15, 32767, 1'b1);
    add_sample(3, -1, 1'b1);
    wait_idle();

    // extremes: max window, all bands, high step, saturating scale
    write_reg(swbp_pkg::REG_WINDOW_LENGTH, 25'd511);
    write_reg(swbp_pkg::REG_BAND_COUNT, 25'd7);
    write_reg(swbp_pkg::REG_BAND_STEP_0, 25'd0);
    write_reg(swbp_pkg::REG_BAND_STEP_1, 25'd32768);
    write_reg(swbp_pkg::REG_BAND_STEP_2, 25'h00FFFF);
    write_reg(swbp_pkg::REG_BAND_STEP_3, 25'd16384);
    write_reg(swbp_pkg::REG_AMPLITUDE_SCALE, 25'h1FFFFFF);
    for (int i = 0; i < 10; i++) add_sample(5, (i % 2) ? 32767 : -32768, 1'b0);
    add_sample(5, 32767, 1'b1);
    add_sample(6, 12345, 1'b1);
    wait_idle();

    // empty window, no bands, minimum scale
    write_reg(swbp_pkg::REG_WINDOW_LENGTH, 25'd0);
    add_sample(5, 100, 1'b1);
    wait_idle();
    write_reg(swbp_pkg::REG_BAND_COUNT, 25'd0);
    add_sample(5, 100, 1'b1);
    wait_idle();
    write_reg(swbp_pkg::REG_WINDOW_LENGTH, 25'd2);
    write_reg(swbp_pkg::REG_BAND_COUNT, 25'd1);
    write_reg(swbp_pkg::REG_AMPLITUDE_SCALE, 25'd0);
    add_sample(7, -32768, 1'b1);
    wait_idle();

    // random phases
    for (int ph = 0; ph < 6; ph++) begin
      random_config(ph == 2);
      add_random_run(28);
      wait_idle();
    end
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(12 * 4000000);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== sliding_window_band_power_unit.f =====
sv/swbp_pkg.sv
sv/swbp_ram.sv
sv/swbp_cordic.sv
sv/swbp_dp.sv
sv/swbp_ctrl.sv
sv/sliding_window_band_power_unit.sv
tb/sv/sliding_window_band_power_unit_tb.sv
